### hw/rtl/gpcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcm_pkg
// Beat types, register indexes and command codes for the genotype pair
// close match block.
// ----------------------------------------------------------------------------
package gpcm_pkg;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_COMPARE = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_LOCI       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NONMISS_THRESH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESH   = 2'd2;

	localparam int CFG_DATA_W = 17;
	localparam int COUNT_W    = 7;
	localparam int THRESH_W   = 17;
	localparam int Q16_SHIFT  = 16;
	localparam int PROD_W     = THRESH_W + COUNT_W;

	localparam logic [COUNT_W-1:0]  NUM_LOCI_RESET      = 7'd64;
	localparam logic [THRESH_W-1:0] NONMISS_THRESH_RESET = 17'd0;
	localparam logic [THRESH_W-1:0] MATCH_THRESH_RESET   = 17'd65536;

	typedef struct packed {
		logic       func;
		logic [9:0] first_index;
		logic [9:0] second_index;
		logic [5:0] locus;
		logic [7:0] allele_a;
		logic [7:0] allele_b;
	} in_item_t;

	typedef struct packed {
		logic [9:0]         pair_first;
		logic [9:0]         pair_second;
		logic [COUNT_W-1:0] num_non_missing;
		logic [COUNT_W-1:0] match_count;
		logic               is_close;
	} out_item_t;

endpackage

### hw/rtl/genotype_pair_close_match_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genotype_pair_close_match_top
// Genotype store with a pair compare engine that counts non-missing and
// matching loci and flags pairs that meet both fraction thresholds.
// ----------------------------------------------------------------------------
// A load command leaves busy low. A compare command keeps busy high while the
// walk runs over num_loci loci, saturated to MAX_LOCI, and the states after
// it: the walk reads both individuals' entries for one locus per cycle
// through the two read ports of the genotype memory, then a drain state
// empties the read pipeline, a multiply state forms the threshold products
// and a finish state registers the result. The result beat is shown for one
// cycle on result with result_valid high, in the first cycle after busy
// falls; the receiver cannot stall it. Register writes are taken only while
// the block is idle and no command is offered. The store has no reset.
module genotype_pair_close_match_top
	import gpcm_pkg::*;
#(
	parameter int MAX_INDIVIDUALS = 1024,
	parameter int MAX_LOCI        = 64,
	parameter int ALLELE_BITS     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              cmd,
	output logic                  result_valid,
	output out_item_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W   = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
	localparam int LOC_W   = (MAX_LOCI > 1) ? $clog2(MAX_LOCI) : 1;
	localparam int ADDR_W  = IDX_W + LOC_W;
	localparam int DEPTH   = MAX_INDIVIDUALS * (2 ** LOC_W);
	localparam int ENTRY_W = 2 * ALLELE_BITS;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WALK  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0]  num_loci_q;
	logic [THRESH_W-1:0] nonmiss_thresh_q;
	logic [THRESH_W-1:0] match_thresh_q;

	logic [ENTRY_W-1:0] mem [DEPTH];

	logic [IDX_W-1:0]   p_idx_q, q_idx_q;
	logic [9:0]         p_raw_q, q_raw_q;
	logic               p_ok_q, q_ok_q;
	logic [COUNT_W-1:0] walk_q;
	logic [COUNT_W-1:0] loc_q;
	logic [COUNT_W-1:0] nm_q, ma_q;
	logic               vld_s1;
	logic [ENTRY_W-1:0] rd_p_s1, rd_q_s1;
	logic [PROD_W-1:0]  nm_scaled_q, nm_need_q, ma_scaled_q, ma_need_q;
	logic               result_valid_q;
	out_item_t          result_q;

	logic accept, do_load, do_cmp, issue, last_loc;
	logic [ADDR_W-1:0] wr_addr, rd_addr_p, rd_addr_q;
	logic [ENTRY_W-1:0] wr_data;
	logic [ALLELE_BITS-1:0] pa0, pa1, qa0, qa1;
	logic all_present, geno_eq;
	logic [COUNT_W-1:0] walk_next;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = ~busy && ~start;
	assign accept    = start && !busy;
	assign do_load   = accept && (cmd.func == FUNC_LOAD)
		&& (32'(cmd.first_index) < MAX_INDIVIDUALS) && (32'(cmd.locus) < MAX_LOCI);
	assign do_cmp    = accept && (cmd.func == FUNC_COMPARE);

	assign wr_addr = {IDX_W'(cmd.first_index), LOC_W'(cmd.locus)};
	assign wr_data = {ALLELE_BITS'(cmd.allele_a), ALLELE_BITS'(cmd.allele_b)};
	assign rd_addr_p = {p_idx_q, LOC_W'(loc_q)};
	assign rd_addr_q = {q_idx_q, LOC_W'(loc_q)};

	assign walk_next = (32'(num_loci_q) > MAX_LOCI) ? COUNT_W'(MAX_LOCI) : num_loci_q;
	assign issue     = (state_q == ST_WALK) && (loc_q < walk_q);
	assign last_loc  = ({1'b0, loc_q} + 8'd1) >= {1'b0, walk_q};

	assign pa0 = p_ok_q ? rd_p_s1[ENTRY_W-1:ALLELE_BITS] : '0;
	assign pa1 = p_ok_q ? rd_p_s1[ALLELE_BITS-1:0] : '0;
	assign qa0 = q_ok_q ? rd_q_s1[ENTRY_W-1:ALLELE_BITS] : '0;
	assign qa1 = q_ok_q ? rd_q_s1[ALLELE_BITS-1:0] : '0;
	assign all_present = (pa0 != '0) && (pa1 != '0) && (qa0 != '0) && (qa1 != '0);
	assign geno_eq = ((pa0 == qa0) && (pa1 == qa1)) || ((pa0 == qa1) && (pa1 == qa0));

	always_ff @(posedge clk) begin
		if (do_load) begin
			mem[wr_addr] <= wr_data;
		end
		rd_p_s1 <= mem[rd_addr_p];
		rd_q_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_loci_q       <= NUM_LOCI_RESET;
			nonmiss_thresh_q <= NONMISS_THRESH_RESET;
			match_thresh_q   <= MATCH_THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_LOCI:       num_loci_q       <= cfg_data[COUNT_W-1:0];
				CFG_NONMISS_THRESH: nonmiss_thresh_q <= cfg_data[THRESH_W-1:0];
				CFG_MATCH_THRESH:   match_thresh_q   <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vld_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			vld_s1         <= issue;
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (do_cmp) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (last_loc) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_FIN;
				ST_FIN: begin
					state_q        <= ST_IDLE;
					result_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_cmp) begin
			p_raw_q <= cmd.first_index;
			q_raw_q <= cmd.second_index;
			p_idx_q <= IDX_W'(cmd.first_index);
			q_idx_q <= IDX_W'(cmd.second_index);
			p_ok_q  <= 32'(cmd.first_index) < MAX_INDIVIDUALS;
			q_ok_q  <= 32'(cmd.second_index) < MAX_INDIVIDUALS;
			walk_q  <= walk_next;
			loc_q   <= '0;
			nm_q    <= '0;
			ma_q    <= '0;
		end else begin
			if (issue) begin
				loc_q <= loc_q + 1'b1;
			end
			if (vld_s1 && all_present) begin
				nm_q <= nm_q + 1'b1;
				if (geno_eq) begin
					ma_q <= ma_q + 1'b1;
				end
			end
		end
		if (state_q == ST_MUL) begin
			nm_scaled_q <= PROD_W'({nm_q, {Q16_SHIFT{1'b0}}});
			ma_scaled_q <= PROD_W'({ma_q, {Q16_SHIFT{1'b0}}});
			nm_need_q   <= nonmiss_thresh_q * walk_q;
			ma_need_q   <= match_thresh_q * nm_q;
		end
		if (state_q == ST_FIN) begin
			result_q.pair_first      <= p_raw_q;
			result_q.pair_second     <= q_raw_q;
			result_q.num_non_missing <= nm_q;
			result_q.match_count     <= ma_q;
			result_q.is_close        <= (nm_q != '0) && (nm_scaled_q >= nm_need_q)
				&& (ma_scaled_q >= ma_need_q);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_FIN))
		else $error("result beat without a finishing compare");

	a_match_le_nonmiss: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.match_count <= result.num_non_missing))
		else $error("match count exceeds non-missing count");

	a_close_needs_loci: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.is_close) |-> (result.num_non_missing != '0))
		else $error("close flag with no non-missing loci");

	a_cmp_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		do_cmp |=> (state_q == ST_WALK) && busy)
		else $error("compare command did not start the walk");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (loc_q <= walk_q))
		else $error("locus counter ran past the walk length");

endmodule
